### rtl/ring_buffer_deque_core_macros.svh
// Assertion macros for the ring buffer deque core.
`ifndef RING_BUFFER_DEQUE_CORE_MACROS_SVH
`define RING_BUFFER_DEQUE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define RBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RBD_ASSERT_IMPL(label, ante, cons, msg) \
    `RBD_ASSERT(label, (ante) |-> (cons), msg)
`else
`define RBD_ASSERT(label, prop, msg)
`define RBD_ASSERT_IMPL(label, ante, cons, msg)
`endif

`endif

### rtl/rbd_pkg.sv
// Shared constants and types of the ring buffer deque core.
package rbd_pkg;

    localparam int DEPTH = 16;
    localparam int WIDTH = 32;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int OPCODE_W    = 4;
    localparam int VALUE_W     = 32;
    localparam int POSITION_W  = 4;
    localparam int READ_DATA_W = 32;
    localparam int STATUS_W    = 2;
    localparam int OCC_W       = 5;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSHFRONT = 4'd0,
        OP_PUSHBACK  = 4'd1,
        OP_POPFRONT  = 4'd2,
        OP_POPBACK   = 4'd3,
        OP_PEEKFRONT = 4'd4,
        OP_PEEKBACK  = 4'd5,
        OP_GET       = 4'd6,
        OP_SET       = 4'd7,
        OP_CLEAR     = 4'd8,
        OP_REVERSE   = 4'd9
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_INDEX = 2'd3
    } status_t;

    typedef struct packed {
        logic [OCC_W-1:0]       occupancy;
        status_t                status;
        logic [READ_DATA_W-1:0] read_data;
    } result_t;

endpackage

### rtl/rbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/ring_buffer_deque_core.sv
// Top level of the ring buffer deque core: request sequencer and element store.
//
// Requests enter on the s_ group (tdata: opcode, value, position); each returns
// exactly one result on the m_ group (tdata: read_data, status, occupancy).
// A request is taken only while the sequencer is idle, then walks a small
// state machine around one slot-address adder (head plus logical offset, wrapped
// to the store depth) and one store with a registered read port.
// States from acceptance to the registered result:
//   clear, set, push, refused request, unused opcode: EXEC, FINISH
//   pop, peek, get: EXEC, READ, FINISH
//   reverse: EXEC, REV_LO, then REV_HI, REV_WLO, REV_WHI, REV_LO per swap
//   (floor(occupancy / 2) swaps, one read-read-write-write each), then FINISH
// The next request may be accepted the cycle after the result is registered,
// so a waiting result does not hold off the next request. If the receiver
// stalls, the result holds in the output register and the sequencer waits in
// its final state until that register is free.
// Reset empties the deque (head and count to zero, output invalid); the store
// contents are left as they are and are never read before being written.
`include "ring_buffer_deque_core_macros.svh"

module ring_buffer_deque_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // opcode[3:0], value[35:4], position[39:36]
    input  logic [rbd_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_data[31:0], status[33:32], occupancy[38:34], zero pad[39]
    output logic [rbd_pkg::OUT_TDATA_W-1:0] m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_REV_LO,
        S_REV_HI,
        S_REV_WLO,
        S_REV_WHI,
        S_FINISH
    } state_t;

    state_t                                state_reg, state_next;
    rbd_pkg::opcode_t                      op_reg, op_next;
    logic [rbd_pkg::WIDTH-1:0]             val_reg, val_next;
    logic [rbd_pkg::POSITION_W-1:0]        pos_reg, pos_next;
    logic [rbd_pkg::PTR_W-1:0]             idx_reg, idx_next;
    logic [rbd_pkg::WIDTH-1:0]             tmp_reg, tmp_next;
    logic [rbd_pkg::READ_DATA_W-1:0]       rd_reg, rd_next;
    rbd_pkg::status_t                      st_reg, st_next;
    logic [rbd_pkg::PTR_W-1:0]             head_reg, head_next;
    logic [rbd_pkg::CNT_W-1:0]             count_reg, count_next;
    rbd_pkg::result_t                      out_reg, out_next;
    logic                                  out_valid_reg, out_valid_next;

    logic [rbd_pkg::PTR_W-1:0]             offset;
    logic [rbd_pkg::PTR_W:0]               slot_sum;
    logic [rbd_pkg::PTR_W-1:0]             slot;
    logic [rbd_pkg::CNT_W-1:0]             back_off;
    logic [rbd_pkg::CNT_W-1:0]             half;
    logic                                  is_full;
    logic                                  is_empty;
    logic                                  pos_bad;
    logic                                  out_free;

    logic                                  ram_we;
    logic [rbd_pkg::WIDTH-1:0]             ram_wdata;
    logic [rbd_pkg::WIDTH-1:0]             ram_rdata;

    assign back_off = count_reg - rbd_pkg::CNT_W'(1) - rbd_pkg::CNT_W'(idx_reg);
    assign half     = count_reg >> 1;
    assign is_full  = (count_reg >= rbd_pkg::CNT_W'(rbd_pkg::DEPTH));
    assign is_empty = (count_reg == '0);
    assign pos_bad  = (rbd_pkg::CNT_W'(pos_reg) >= count_reg)
                      || (pos_reg > rbd_pkg::POSITION_W'(rbd_pkg::DEPTH - 1));
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        offset = '0;
        case (state_reg)
            S_EXEC:
            begin
                case (op_reg)
                    rbd_pkg::OP_PUSHFRONT: offset = rbd_pkg::PTR_W'(rbd_pkg::DEPTH - 1);
                    rbd_pkg::OP_PUSHBACK:  offset = count_reg[rbd_pkg::PTR_W-1:0];
                    rbd_pkg::OP_POPBACK,
                    rbd_pkg::OP_PEEKBACK:  offset = back_off[rbd_pkg::PTR_W-1:0];
                    rbd_pkg::OP_GET,
                    rbd_pkg::OP_SET:       offset = rbd_pkg::PTR_W'(pos_reg);
                    default:               offset = '0;
                endcase
            end
            S_READ:    offset = rbd_pkg::PTR_W'(1);
            S_REV_LO,
            S_REV_WLO: offset = idx_reg;
            S_REV_HI,
            S_REV_WHI: offset = back_off[rbd_pkg::PTR_W-1:0];
            default:   offset = '0;
        endcase
    end

    assign slot_sum = {1'b0, head_reg} + {1'b0, offset};
    assign slot = (slot_sum >= (rbd_pkg::PTR_W + 1)'(rbd_pkg::DEPTH))
                  ? rbd_pkg::PTR_W'(slot_sum - (rbd_pkg::PTR_W + 1)'(rbd_pkg::DEPTH))
                  : slot_sum[rbd_pkg::PTR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        tmp_next       = tmp_reg;
        rd_next        = rd_reg;
        st_next        = st_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ram_we         = 1'b0;
        ram_wdata      = val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = rbd_pkg::opcode_t'(s_tdata[3:0]);
                    val_next   = rbd_pkg::WIDTH'(s_tdata[35:4]);
                    pos_next   = s_tdata[39:36];
                    rd_next    = '0;
                    st_next    = rbd_pkg::ST_OK;
                    idx_next   = '0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FINISH;
                case (op_reg)
                    rbd_pkg::OP_PUSHFRONT:
                    begin
                        if (is_full)
                        begin
                            st_next = rbd_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            head_next  = slot;
                            count_next = count_reg + rbd_pkg::CNT_W'(1);
                        end
                    end
                    rbd_pkg::OP_PUSHBACK:
                    begin
                        if (is_full)
                        begin
                            st_next = rbd_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + rbd_pkg::CNT_W'(1);
                        end
                    end
                    rbd_pkg::OP_POPFRONT,
                    rbd_pkg::OP_POPBACK,
                    rbd_pkg::OP_PEEKFRONT,
                    rbd_pkg::OP_PEEKBACK:
                    begin
                        if (is_empty)
                        begin
                            st_next = rbd_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    rbd_pkg::OP_GET:
                    begin
                        if (pos_bad)
                        begin
                            st_next = rbd_pkg::ST_INDEX;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    rbd_pkg::OP_SET:
                    begin
                        if (pos_bad)
                        begin
                            st_next = rbd_pkg::ST_INDEX;
                        end
                        else
                        begin
                            ram_we = 1'b1;
                        end
                    end
                    rbd_pkg::OP_CLEAR:
                    begin
                        head_next  = '0;
                        count_next = '0;
                    end
                    rbd_pkg::OP_REVERSE:
                    begin
                        state_next = S_REV_LO;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_READ:
            begin
                rd_next    = rbd_pkg::READ_DATA_W'(ram_rdata);
                state_next = S_FINISH;
                if (op_reg == rbd_pkg::OP_POPFRONT)
                begin
                    head_next  = slot;
                    count_next = count_reg - rbd_pkg::CNT_W'(1);
                end
                else if (op_reg == rbd_pkg::OP_POPBACK)
                begin
                    count_next = count_reg - rbd_pkg::CNT_W'(1);
                end
            end
            S_REV_LO:
            begin
                if (rbd_pkg::CNT_W'(idx_reg) < half)
                begin
                    state_next = S_REV_HI;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_REV_HI:
            begin
                tmp_next   = ram_rdata;
                state_next = S_REV_WLO;
            end
            S_REV_WLO:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                state_next = S_REV_WHI;
            end
            S_REV_WHI:
            begin
                ram_we     = 1'b1;
                ram_wdata  = tmp_reg;
                idx_next   = idx_reg + rbd_pkg::PTR_W'(1);
                state_next = S_REV_LO;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_next.read_data = rd_reg;
                    out_next.status    = st_reg;
                    out_next.occupancy = rbd_pkg::OCC_W'(count_reg);
                    out_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        val_reg <= val_next;
        pos_reg <= pos_next;
        idx_reg <= idx_next;
        tmp_reg <= tmp_next;
        rd_reg  <= rd_next;
        st_reg  <= st_next;
        out_reg <= out_next;
    end

    rbd_ram #(
        .WIDTH (rbd_pkg::WIDTH),
        .DEPTH (rbd_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (ram_wdata),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rbd_pkg::OUT_TDATA_W'(out_reg);

    `RBD_ASSERT(a_count_bound, count_reg <= rbd_pkg::CNT_W'(rbd_pkg::DEPTH),
        "element count exceeds depth")
    `RBD_ASSERT_IMPL(a_count_step, count_reg != $past(count_reg),
        count_reg == $past(count_reg) + rbd_pkg::CNT_W'(1)
        || count_reg == $past(count_reg) - rbd_pkg::CNT_W'(1) || count_reg == '0,
        "element count moved by more than one")
    `RBD_ASSERT_IMPL(a_occ_match, $rose(m_tvalid),
        m_tdata[38:34] == rbd_pkg::OCC_W'(count_reg),
        "result occupancy differs from element count")
    `RBD_ASSERT_IMPL(a_refused_zero, m_tvalid && m_tdata[33:32] != rbd_pkg::ST_OK,
        m_tdata[31:0] == '0, "refused request returned nonzero data")

endmodule
